FILE: rtl/bmp_fb_pkg.sv
// ----------------------------------------------------------------------------
// BMP frame buffer blit package
// Request types, header offsets and register indexes shared by the blit RTL.
// ----------------------------------------------------------------------------
package bmp_fb_pkg;

	localparam int HDR_W     = 6;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int FB_ADDR_W = 19;
	localparam int PIXEL_W   = 24;

	// Largest origin value a 10-bit register can hold.
	localparam int ORIGIN_MAX = 1023;

	localparam logic [HDR_W-1:0] WIDTH_OFFSET  = 6'd18;
	localparam logic [HDR_W-1:0] WIDTH_LAST    = 6'd21;
	localparam logic [HDR_W-1:0] HEIGHT_LAST   = 6'd25;
	localparam logic [HDR_W-1:0] HEADER_END    = 6'd26;
	localparam logic [HDR_W-1:0] PIXEL_OFFSET  = 6'd54;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL = 1'd1;

	typedef enum logic [1:0] {
		BIP_BLUE,
		BIP_GREEN,
		BIP_RED
	} bip_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [FB_ADDR_W-1:0] fb_address;
		logic [PIXEL_W-1:0]   pixel_word;
		logic                 in_range;
		logic                 last_pixel;
	} out_item_t;

endpackage

FILE: rtl/bmp_pixel_stream_to_framebuffer.sv
// ----------------------------------------------------------------------------
// BMP pixel stream to frame buffer
// Parses a 24-bit BMP byte stream and emits one frame buffer write per pixel.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction  Contents
//  in        in_valid / in_ready / in_data    sink       file byte, start mark
//  out       out_valid / out_ready / out_data source     address, pixel, flags
//  cfg       cfg_we / cfg_index / cfg_wdata   sink       origin row and column
//
//  One byte is taken per cycle while in_ready is high; every third pixel byte yields one result.
//  After its last byte a result is registered in the parse stage, then the
//  address multiply and range compare into the output register.
//  A stall on out_ready backs up through both stages to in_ready.
//  Reset leaves the block idle until a byte marked as an image start.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_to_framebuffer #(
	parameter int FRAME_WIDTH = 640,
	parameter int FB_WORDS    = 524288,
	parameter int MAX_DIM     = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bmp_fb_pkg::in_item_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bmp_fb_pkg::out_item_t                out_data,
	input  logic                                 cfg_we,
	input  logic [bmp_fb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmp_fb_pkg::CFG_W-1:0]         cfg_wdata
);
	import bmp_fb_pkg::*;

	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int POS_MAX  = ORIGIN_MAX + MAX_DIM;
	localparam int POS_W    = $clog2(POS_MAX);
	localparam int ADDR_MAX = (POS_MAX - 1) * FRAME_WIDTH + POS_MAX - 1;
	localparam int ADDR_W   = $clog2(ADDR_MAX + 1);
	localparam int CMP_W    = $clog2(FB_WORDS + 1);
	localparam int EXT_A    = (ADDR_W > CMP_W) ? ADDR_W : CMP_W;
	localparam int EXT_W    = (EXT_A > FB_ADDR_W) ? EXT_A : FB_ADDR_W;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [31:0] raw);
		logic [DIM_W-1:0] res;
		if (raw == 32'd0 || raw[31]) begin
			res = '0;
		end else if (raw > 32'(MAX_DIM)) begin
			res = DIM_W'(MAX_DIM);
		end else begin
			res = raw[DIM_W-1:0];
		end
		return res;
	endfunction

	// Configuration registers
	logic [CFG_W-1:0] origin_row_q, origin_col_q;

	// Parse state
	logic [HDR_W-1:0] hdr_q, hdr_d, cur_hdr;
	logic [DIM_W-1:0] w_q, w_d, cur_w;
	logic [DIM_W-1:0] h_q, h_d, cur_h;
	logic [DIM_W-1:0] col_q, col_d, cur_col;
	logic [DIM_W-1:0] row_q, row_d, cur_row;
	bip_t             bip_q, bip_d, cur_bip;
	logic [1:0]       pad_q, pad_d, cur_pad;
	logic             done_q, done_d, cur_done;
	logic [7:0]       blue_q, blue_d, green_q, green_d;
	logic [31:0]      acc_q, acc_d, acc_new;
	logic [HDR_W-1:0] hdr_rel;

	logic accept, pix_fire, last_col, last_pix;
	logic [POS_W-1:0] row_pos, col_pos;

	// Pipeline
	logic                 valid_s1;
	logic [POS_W-1:0]     row_s1, col_s1;
	logic [PIXEL_W-1:0]   pixel_s1;
	logic                 last_s1;
	logic                 s1_en, s2_en;
	logic                 out_valid_s2;
	out_item_t            out_data_s2;
	logic [EXT_W-1:0]     addr_full;

	assign s2_en    = !out_valid_s2 || out_ready;
	assign s1_en    = !valid_s1 || s2_en;
	assign in_ready = s1_en;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_row_q <= '0;
			origin_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_ROW: origin_row_q <= cfg_wdata;
				REG_ORIGIN_COL: origin_col_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		// A start mark restarts parsing with this byte as byte zero.
		cur_hdr  = in_data.image_start ? '0 : hdr_q;
		cur_w    = in_data.image_start ? '0 : w_q;
		cur_h    = in_data.image_start ? '0 : h_q;
		cur_col  = in_data.image_start ? '0 : col_q;
		cur_row  = in_data.image_start ? '0 : row_q;
		cur_bip  = in_data.image_start ? BIP_BLUE : bip_q;
		cur_pad  = in_data.image_start ? 2'd0 : pad_q;
		cur_done = in_data.image_start ? 1'b0 : done_q;

		hdr_d   = cur_hdr;
		w_d     = cur_w;
		h_d     = cur_h;
		col_d   = cur_col;
		row_d   = cur_row;
		bip_d   = cur_bip;
		pad_d   = cur_pad;
		done_d  = cur_done;
		blue_d  = blue_q;
		green_d = green_q;
		acc_d   = acc_q;
		acc_new = acc_q;
		hdr_rel = cur_hdr - WIDTH_OFFSET;
		pix_fire = 1'b0;

		last_col = (DIM_W'(cur_col + 1'b1) == cur_w);
		last_pix = last_col && (DIM_W'(cur_row + 1'b1) == cur_h);
		// Rows are stored bottom up.
		row_pos = POS_W'(origin_row_q) + POS_W'(cur_h) - POS_W'(1) - POS_W'(cur_row);
		col_pos = POS_W'(origin_col_q) + POS_W'(cur_col);

		if (!cur_done) begin
			if (cur_hdr < PIXEL_OFFSET) begin
				if (cur_hdr >= WIDTH_OFFSET && cur_hdr < HEADER_END) begin
					case (hdr_rel[1:0])
						2'd0:    acc_new = {24'd0, in_data.file_byte};
						2'd1:    acc_new = acc_q | {16'd0, in_data.file_byte, 8'd0};
						2'd2:    acc_new = acc_q | {8'd0, in_data.file_byte, 16'd0};
						default: acc_new = acc_q | {in_data.file_byte, 24'd0};
					endcase
					acc_d = acc_new;
					if (cur_hdr == WIDTH_LAST) begin
						w_d = clamp_dim(acc_new);
					end
					if (cur_hdr == HEIGHT_LAST) begin
						h_d = clamp_dim(acc_new);
					end
				end
				hdr_d = cur_hdr + 1'b1;
				if (hdr_d == PIXEL_OFFSET && (w_d == '0 || h_d == '0)) begin
					done_d = 1'b1;
				end
			end else if (cur_pad != 2'd0) begin
				pad_d = cur_pad - 1'b1;
			end else begin
				case (cur_bip)
					BIP_BLUE: begin
						blue_d = in_data.file_byte;
						bip_d  = BIP_GREEN;
					end
					BIP_GREEN: begin
						green_d = in_data.file_byte;
						bip_d   = BIP_RED;
					end
					BIP_RED: begin
						bip_d    = BIP_BLUE;
						pix_fire = 1'b1;
						if (last_col) begin
							col_d = '0;
							row_d = cur_row + 1'b1;
							// Padding to a 4-byte row equals width mod 4 for 3-byte pixels.
							pad_d = 2'(cur_w);
						end else begin
							col_d = cur_col + 1'b1;
						end
						if (last_pix) begin
							done_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q  <= '0;
			w_q    <= '0;
			h_q    <= '0;
			col_q  <= '0;
			row_q  <= '0;
			bip_q  <= BIP_BLUE;
			pad_q  <= 2'd0;
			done_q <= 1'b1;
		end else if (accept) begin
			hdr_q  <= hdr_d;
			w_q    <= w_d;
			h_q    <= h_d;
			col_q  <= col_d;
			row_q  <= row_d;
			bip_q  <= bip_d;
			pad_q  <= pad_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_q  <= blue_d;
			green_q <= green_d;
			acc_q   <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= accept && pix_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			row_s1   <= row_pos;
			col_s1   <= col_pos;
			pixel_s1 <= {blue_q, green_q, in_data.file_byte};
			last_s1  <= last_pix;
		end
	end

	assign addr_full = EXT_W'(row_s1) * EXT_W'(FRAME_WIDTH) + EXT_W'(col_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_en) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en) begin
			out_data_s2.fb_address <= addr_full[FB_ADDR_W-1:0];
			out_data_s2.pixel_word <= pixel_s1;
			out_data_s2.in_range   <= (addr_full < EXT_W'(FB_WORDS));
			out_data_s2.last_pixel <= last_s1;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	a_hdr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q <= PIXEL_OFFSET)
		else $error("header count ran past the pixel offset");

	a_pad_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q != 2'd0 |-> bip_q == BIP_BLUE)
		else $error("row padding pending in the middle of a pixel");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!done_q && hdr_q == PIXEL_OFFSET) |-> (col_q < w_q && row_q < h_q))
		else $error("pixel position outside the image while active");

endmodule
